[hdl/mvne_pkg.sv]
`timescale 1ns / 1ps
package mvne_pkg;

	// command codes
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_ADD   = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_ACK    = 2'd0;
	localparam logic [1:0] KIND_FACE   = 2'd1;
	localparam logic [1:0] KIND_VERTEX = 2'd2;

	// Q1.14 one, sum limits
	localparam logic [15:0] UNIT = 16'd16384;
	localparam logic signed [23:0] SUM_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] SUM_MIN = 24'sh800000;

	// magnitude window after normalizing shift
	localparam logic [35:0] MAG_LO = 36'h0_2000_0000;
	localparam logic [35:0] MAG_HI = 36'h0_4000_0000;

	typedef logic [1:0]         code_t;
	typedef logic signed [15:0] coord_t;
	typedef logic [9:0]         slot_t;

	// one accumulator entry
	typedef struct packed {
		logic signed [23:0] sx;
		logic signed [23:0] sy;
		logic signed [23:0] sz;
		logic [7:0]         cnt;
	} acc_entry_t;

	typedef enum logic [17:0] {
		ST_CLEAR = 18'b000000000000000001,
		ST_IDLE  = 18'b000000000000000010,
		ST_RPA   = 18'b000000000000000100,
		ST_RPB   = 18'b000000000000001000,
		ST_RPC   = 18'b000000000000010000,
		ST_EDGE  = 18'b000000000000100000,
		ST_CROSS = 18'b000000000001000000,
		ST_MAG   = 18'b000000000010000000,
		ST_SHIFT = 18'b000000000100000000,
		ST_SQ    = 18'b000000001000000000,
		ST_SQRT  = 18'b000000010000000000,
		ST_DVLD  = 18'b000000100000000000,
		ST_DIV   = 18'b000001000000000000,
		ST_ARD   = 18'b000010000000000000,
		ST_AWR   = 18'b000100000000000000,
		ST_VRD   = 18'b001000000000000000,
		ST_VCHK  = 18'b010000000000000000,
		ST_DONE  = 18'b100000000000000000
	} state_t;

endpackage

[hdl/mvne_cmd_if.sv]
`timescale 1ns / 1ps
interface mvne_cmd_if;
	import mvne_pkg::*;

	logic   valid;
	logic   ready;
	code_t  command;
	coord_t pos_x;
	coord_t pos_y;
	coord_t pos_z;
	slot_t  corner_a;
	slot_t  corner_b;
	slot_t  corner_c;

	modport source (output valid, command, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c,
		input ready);
	modport sink (input valid, command, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c,
		output ready);
endinterface

[hdl/mvne_res_if.sv]
`timescale 1ns / 1ps
interface mvne_res_if;
	import mvne_pkg::*;

	logic   valid;
	logic   ready;
	code_t  result_kind;
	coord_t normal_x;
	coord_t normal_y;
	coord_t normal_z;
	logic   degenerate;

	modport source (output valid, result_kind, normal_x, normal_y, normal_z, degenerate,
		input ready);
	modport sink (input valid, result_kind, normal_x, normal_y, normal_z, degenerate,
		output ready);
endinterface

[hdl/mesh_vertex_normal_engine.sv]
`timescale 1ns / 1ps
// Channel | Dir | Payload
// cmd     | in  | command, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c
// res     | out | result_kind, normal_x, normal_y, normal_z, degenerate
//
// One command at a time; every command gives one result.
// Vertex read: three 24-step divides, none with no triangles.
// Triangle add: the normalizing shift (one bit a cycle),
// the 31-step square root and three 16-step divides sharing one divider; none if zero-length.
// After reset the sum/count memory is cleared, one entry a cycle.
// A finished result waits in the output register; a new command is taken meanwhile.
module mesh_vertex_normal_engine #(
	parameter int VERTEX_SLOTS = 1024
) (
	input logic       clk,
	input logic       arst_n,
	mvne_cmd_if.sink  cmd,
	mvne_res_if.source res
);
	import mvne_pkg::*;

	localparam int AW = (VERTEX_SLOTS > 1) ? $clog2(VERTEX_SLOTS) : 1;

	// slot number modulo the store depth, compare and subtract over eight steps
	function automatic logic [AW-1:0] slot_of(input logic [9:0] v);
		logic [24:0] r;
		r = {15'b0, v};
		for (int k = 7; k >= 0; k--) begin
			if (r >= (25'(VERTEX_SLOTS) << k)) begin
				r = r - (25'(VERTEX_SLOTS) << k);
			end
		end
		return AW'(r);
	endfunction

	function automatic logic signed [23:0] sat_add(input logic signed [23:0] s,
		input logic signed [15:0] n);
		logic signed [24:0] t;
		t = 25'(s) + 25'(n);
		if (t[24] != t[23]) begin
			return t[24] ? SUM_MIN : SUM_MAX;
		end
		return t[23:0];
	endfunction

	// memories
	logic [47:0]   pos_mem [VERTEX_SLOTS];
	acc_entry_t    acc_mem [VERTEX_SLOTS];
	logic [47:0]   pos_rd_q;
	acc_entry_t    acc_rd_q;

	// control
	state_t        state_q;
	logic [AW-1:0] clr_q;
	logic [5:0]    cnt_q;
	logic [1:0]    k_q;
	logic          res_valid_q;

	// datapath
	logic [AW-1:0]      slot_q [3];
	logic [1:0]         cmd_q;
	logic [47:0]        pa_q, pb_q;
	logic signed [16:0] e1_q [3];
	logic signed [16:0] e2_q [3];
	logic signed [33:0] prod_q;
	logic signed [35:0] cr_q [3];
	logic [35:0]        m_q [3];
	logic               sgn_q [3];
	logic [59:0]        sq_q;
	logic [61:0]        s_q;
	logic [33:0]        rem_q;
	logic [30:0]        root_q;
	logic [23:0]        num_q;
	logic [31:0]        dvs_q;
	logic [23:0]        quo_q;
	logic               div_avg_q;
	logic signed [23:0] sum_q [3];
	logic [7:0]         cntv_q;
	logic signed [15:0] nrm_q [3];
	logic               deg_q;
	logic [1:0]         out_kind_q;
	logic signed [15:0] out_x_q, out_y_q, out_z_q;
	logic               out_deg_q;

	logic cmd_xfer;
	assign cmd_xfer = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == ST_IDLE);

	// memory ports
	logic [AW-1:0] pos_ra, acc_ra, acc_wa;
	logic          acc_we;
	acc_entry_t    acc_wd, acc_upd;

	always_comb begin
		acc_upd.sx  = sat_add(acc_rd_q.sx, nrm_q[0]);
		acc_upd.sy  = sat_add(acc_rd_q.sy, nrm_q[1]);
		acc_upd.sz  = sat_add(acc_rd_q.sz, nrm_q[2]);
		acc_upd.cnt = (acc_rd_q.cnt == 8'd255) ? acc_rd_q.cnt : acc_rd_q.cnt + 8'd1;
		pos_ra = (state_q == ST_RPA) ? slot_q[0] : (state_q == ST_RPB) ? slot_q[1] : slot_q[2];
		acc_ra = (state_q == ST_VRD) ? slot_q[0] : slot_q[k_q];
		acc_we = (state_q == ST_CLEAR) || (state_q == ST_AWR);
		acc_wa = (state_q == ST_CLEAR) ? clr_q : slot_q[k_q];
		acc_wd = (state_q == ST_CLEAR) ? '0 : acc_upd;
	end

	always_ff @(posedge clk) begin
		if (cmd_xfer && cmd.command == CMD_WRITE) begin
			pos_mem[slot_of(cmd.corner_a)] <= {cmd.pos_x, cmd.pos_y, cmd.pos_z};
		end
		pos_rd_q <= pos_mem[pos_ra];
	end

	always_ff @(posedge clk) begin
		if (acc_we) begin
			acc_mem[acc_wa] <= acc_wd;
		end
		acc_rd_q <= acc_mem[acc_ra];
	end

	// cross product operand select
	logic signed [16:0] mul_a, mul_b;
	always_comb begin
		case (cnt_q[2:0])
			3'd0: begin mul_a = e1_q[1]; mul_b = e2_q[2]; end
			3'd1: begin mul_a = e1_q[2]; mul_b = e2_q[1]; end
			3'd2: begin mul_a = e1_q[2]; mul_b = e2_q[0]; end
			3'd3: begin mul_a = e1_q[0]; mul_b = e2_q[2]; end
			3'd4: begin mul_a = e1_q[0]; mul_b = e2_q[1]; end
			3'd5: begin mul_a = e1_q[1]; mul_b = e2_q[0]; end
			default: begin mul_a = e1_q[1]; mul_b = e2_q[2]; end
		endcase
	end

	// largest magnitude
	logic [35:0] mx;
	always_comb begin
		mx = (m_q[0] > m_q[1]) ? m_q[0] : m_q[1];
		if (m_q[2] > mx) mx = m_q[2];
	end

	logic cr_zero;
	assign cr_zero = (cr_q[0] == '0) && (cr_q[1] == '0) && (cr_q[2] == '0);

	// square root step
	logic [33:0] sqt_t, sqt_trial;
	logic        sqt_ge;
	assign sqt_t     = {rem_q[31:0], s_q[61:60]};
	assign sqt_trial = {1'b0, root_q, 2'b01};
	assign sqt_ge    = sqt_t >= sqt_trial;

	// divide step
	logic [32:0] div_t;
	logic        div_ge;
	logic [23:0] quo_next;
	logic [15:0] quo_clamp;
	logic        div_last;
	assign div_t     = {rem_q[31:0], num_q[23]};
	assign div_ge    = div_t >= {1'b0, dvs_q};
	assign quo_next  = {quo_q[22:0], div_ge};
	assign quo_clamp = (quo_next > 24'(UNIT)) ? UNIT : quo_next[15:0];
	assign div_last  = div_avg_q ? (cnt_q == 6'd23) : (cnt_q == 6'd15);

	// divider load values
	logic [44:0] n_face;
	logic [23:0] mag_avg;
	logic [23:0] n_avg;
	assign n_face  = {1'b0, m_q[k_q][29:0], 14'b0} + 45'(root_q >> 1);
	assign mag_avg = sum_q[k_q][23] ? 24'(-sum_q[k_q]) : 24'(sum_q[k_q]);
	assign n_avg   = mag_avg + 24'(cntv_q >> 1);

	// result valid: set when a result is loaded, cleared on its transfer
	logic out_load;
	assign out_load = (state_q == ST_DONE) && (!res_valid_q || res.ready);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			k_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (res.valid && res.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(VERTEX_SLOTS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cmd_xfer) begin
						unique case (cmd.command)
							CMD_ADD:  state_q <= ST_RPA;
							CMD_READ: state_q <= ST_VRD;
							default:  state_q <= ST_DONE;
						endcase
					end
				end
				ST_RPA: state_q <= ST_RPB;
				ST_RPB: state_q <= ST_RPC;
				ST_RPC: state_q <= ST_EDGE;
				ST_EDGE: begin
					cnt_q   <= '0;
					state_q <= ST_CROSS;
				end
				ST_CROSS: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd6) state_q <= ST_MAG;
				end
				ST_MAG: begin
					k_q     <= '0;
					state_q <= cr_zero ? ST_ARD : ST_SHIFT;
				end
				ST_SHIFT: begin
					cnt_q <= '0;
					if (mx >= MAG_LO && mx < MAG_HI) state_q <= ST_SQ;
				end
				ST_SQ: begin
					if (cnt_q == 6'd3) begin
						cnt_q   <= '0;
						state_q <= ST_SQRT;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_SQRT: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd30) begin
						k_q     <= '0;
						state_q <= ST_DVLD;
					end
				end
				ST_DVLD: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (div_last) begin
						if (k_q == 2'd2) begin
							k_q     <= '0;
							state_q <= div_avg_q ? ST_DONE : ST_ARD;
						end else begin
							k_q     <= k_q + 2'd1;
							state_q <= ST_DVLD;
						end
					end
				end
				ST_ARD: state_q <= ST_AWR;
				ST_AWR: begin
					if (k_q == 2'd2) begin
						state_q <= ST_DONE;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= ST_ARD;
					end
				end
				ST_VRD: state_q <= ST_VCHK;
				ST_VCHK: begin
					k_q     <= '0;
					state_q <= (acc_rd_q.cnt == 8'd0) ? ST_DONE : ST_DVLD;
				end
				ST_DONE: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd_xfer) begin
					cmd_q     <= cmd.command;
					slot_q[0] <= slot_of(cmd.corner_a);
					slot_q[1] <= slot_of(cmd.corner_b);
					slot_q[2] <= slot_of(cmd.corner_c);
					for (int i = 0; i < 3; i++) nrm_q[i] <= '0;
					deg_q     <= 1'b0;
					div_avg_q <= (cmd.command == CMD_READ);
				end
			end
			ST_RPB: pa_q <= pos_rd_q;
			ST_RPC: pb_q <= pos_rd_q;
			ST_EDGE: begin
				for (int i = 0; i < 3; i++) begin
					e1_q[i] <= 17'(signed'(pb_q[47-16*i -: 16])) -
						17'(signed'(pa_q[47-16*i -: 16]));
					e2_q[i] <= 17'(signed'(pos_rd_q[47-16*i -: 16])) -
						17'(signed'(pa_q[47-16*i -: 16]));
				end
			end
			ST_CROSS: begin
				if (cnt_q < 6'd6) prod_q <= mul_a * mul_b;
				if (cnt_q != 6'd0) begin
					if (cnt_q[0]) begin
						cr_q[2'((cnt_q - 6'd1) >> 1)] <= 36'(prod_q);
					end else begin
						cr_q[2'((cnt_q - 6'd1) >> 1)] <= cr_q[2'((cnt_q - 6'd1) >> 1)]
							- 36'(prod_q);
					end
				end
			end
			ST_MAG: begin
				for (int i = 0; i < 3; i++) begin
					m_q[i]   <= cr_q[i][35] ? 36'(-cr_q[i]) : 36'(cr_q[i]);
					sgn_q[i] <= cr_q[i][35];
				end
				deg_q <= cr_zero;
			end
			ST_SHIFT: begin
				if (mx < MAG_LO) begin
					for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
				end else if (mx >= MAG_HI) begin
					for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
				end
				s_q <= '0;
			end
			ST_SQ: begin
				if (cnt_q < 6'd3) sq_q <= m_q[cnt_q[1:0]][29:0] * m_q[cnt_q[1:0]][29:0];
				if (cnt_q != 6'd0) s_q <= s_q + 62'(sq_q);
				rem_q  <= '0;
				root_q <= '0;
			end
			ST_SQRT: begin
				rem_q  <= sqt_ge ? sqt_t - sqt_trial : sqt_t;
				root_q <= {root_q[29:0], sqt_ge};
				s_q    <= s_q << 2;
			end
			ST_DVLD: begin
				quo_q <= '0;
				if (div_avg_q) begin
					rem_q <= '0;
					num_q <= n_avg;
					dvs_q <= 32'(cntv_q);
				end else begin
					rem_q <= 34'(n_face[44:16]);
					num_q <= {n_face[15:0], 8'b0};
					dvs_q <= 32'(root_q);
				end
			end
			ST_DIV: begin
				rem_q <= div_ge ? 34'(div_t - {1'b0, dvs_q}) : 34'(div_t);
				num_q <= num_q << 1;
				quo_q <= quo_next;
				if (div_last) begin
					nrm_q[k_q] <= sgn_q[k_q] ? -signed'(quo_clamp) : signed'(quo_clamp);
				end
			end
			ST_VCHK: begin
				sum_q[0] <= acc_rd_q.sx;
				sum_q[1] <= acc_rd_q.sy;
				sum_q[2] <= acc_rd_q.sz;
				sgn_q[0] <= acc_rd_q.sx[23];
				sgn_q[1] <= acc_rd_q.sy[23];
				sgn_q[2] <= acc_rd_q.sz[23];
				cntv_q   <= acc_rd_q.cnt;
				deg_q    <= (acc_rd_q.cnt == 8'd0);
			end
			ST_DONE: begin
				if (out_load) begin
					unique case (cmd_q)
						CMD_ADD:  out_kind_q <= KIND_FACE;
						CMD_READ: out_kind_q <= KIND_VERTEX;
						default:  out_kind_q <= KIND_ACK;
					endcase
					out_x_q   <= nrm_q[0];
					out_y_q   <= nrm_q[1];
					out_z_q   <= nrm_q[2];
					out_deg_q <= deg_q;
				end
			end
			default: ;
		endcase
	end

	// result port
	assign res.valid       = res_valid_q;
	assign res.result_kind = out_kind_q;
	assign res.normal_x    = out_x_q;
	assign res.normal_y    = out_y_q;
	assign res.normal_z    = out_z_q;
	assign res.degenerate  = out_deg_q;

	// checks
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.normal_x <= 16'sd16384 && res.normal_x >= -16'sd16384 &&
			res.normal_y <= 16'sd16384 && res.normal_y >= -16'sd16384 &&
			res.normal_z <= 16'sd16384 && res.normal_z >= -16'sd16384))
		else $error("normal component out of range");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.degenerate |->
			(res.normal_x == '0 && res.normal_y == '0 && res.normal_z == '0))
		else $error("degenerate result with nonzero normal");

	a_ack_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.result_kind == KIND_ACK |-> !res.degenerate)
		else $error("acknowledge flagged degenerate");

	a_shift_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SQ && cnt_q == 6'd0 |-> (mx >= MAG_LO && mx < MAG_HI))
		else $error("normalizing shift left magnitude outside window");

	a_root_floor: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DVLD && !div_avg_q |-> root_q[30:29] != 2'b00)
		else $error("square root below expected floor");
endmodule

[verif/mesh_vertex_normal_engine_tb.sv]
`timescale 1ns / 1ps
module mesh_vertex_normal_engine_tb;
	import mvne_pkg::*;

	localparam int SLOTS = 1024;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_ITEMS = 1350;
	// slots reserved for the repeated triangle that drives sums and counts to their limits
	localparam slot_t HOT_ORIGIN = 10'd0;
	localparam slot_t HOT_X = 10'd1;
	localparam slot_t HOT_Y = 10'd2;

	typedef struct {
		code_t  command;
		coord_t pos_x;
		coord_t pos_y;
		coord_t pos_z;
		slot_t  corner_a;
		slot_t  corner_b;
		slot_t  corner_c;
	} cmd_item_t;

	typedef struct {
		code_t  result_kind;
		coord_t normal_x;
		coord_t normal_y;
		coord_t normal_z;
		logic   degenerate;
	} normal_item_t;

	// Tracks vertex positions and running normal sums, predicts every result.
	class normal_scoreboard;
		int          vert_pos[SLOTS][3];
		int          normal_sum[SLOTS][3];
		int unsigned tri_count[SLOTS];
		normal_item_t expected_normals[$];
		int          errors;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				tri_count[i] = 0;
				for (int k = 0; k < 3; k++) begin
					vert_pos[i][k] = 0;
					normal_sum[i][k] = 0;
				end
			end
			errors = 0;
		endfunction

		function longint unsigned int_sqrt(longint unsigned val);
			longint unsigned root;
			longint unsigned probe;
			root = 0;
			probe = 64'd1 << 62;
			while (probe > val)
				probe >>= 2;
			while (probe != 0) begin
				if (val >= root + probe) begin
					val -= root + probe;
					root = (root >> 1) + probe;
				end else begin
					root >>= 1;
				end
				probe >>= 2;
			end
			return root;
		endfunction

		function int sat_sum(int acc, int addend);
			longint total;
			total = longint'(acc) + longint'(addend);
			if (total > 8388607)
				total = 8388607;
			if (total < -8388608)
				total = -8388608;
			return int'(total);
		endfunction

		function int rounded_avg(int acc, int unsigned cnt);
			int unsigned mag;
			int unsigned q;
			mag = acc < 0 ? -acc : acc;
			q = (mag + cnt / 2) / cnt;
			if (q > UNIT)
				q = UNIT;
			return acc < 0 ? -int'(q) : int'(q);
		endfunction

		function int pending();
			return expected_normals.size();
		endfunction

		// accepted command: update the model and queue its result
		function void note_command(cmd_item_t it);
			normal_item_t exp_res;
			longint e1[3], e2[3], cr[3];
			longint unsigned mag[3];
			longint unsigned peak, sq_sum, len, q;
			int nrm[3];
			int corner[3];
			nrm = '{0, 0, 0};
			exp_res.result_kind = KIND_ACK;
			exp_res.degenerate = 1'b0;
			case (it.command)
				CMD_WRITE: begin
					vert_pos[it.corner_a][0] = it.pos_x;
					vert_pos[it.corner_a][1] = it.pos_y;
					vert_pos[it.corner_a][2] = it.pos_z;
				end
				CMD_ADD: begin
					corner = '{it.corner_a, it.corner_b, it.corner_c};
					for (int i = 0; i < 3; i++) begin
						e1[i] = longint'(vert_pos[corner[1]][i]) - vert_pos[corner[0]][i];
						e2[i] = longint'(vert_pos[corner[2]][i]) - vert_pos[corner[0]][i];
					end
					cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
					cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
					cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
					peak = 0;
					for (int i = 0; i < 3; i++) begin
						mag[i] = cr[i] < 0 ? -cr[i] : cr[i];
						if (mag[i] > peak)
							peak = mag[i];
					end
					if (peak == 0) begin
						exp_res.degenerate = 1'b1;
					end else begin
						// bring the largest magnitude into [2^29, 2^30)
						while (peak < (64'd1 << 29)) begin
							for (int i = 0; i < 3; i++)
								mag[i] <<= 1;
							peak <<= 1;
						end
						while (peak >= (64'd1 << 30)) begin
							for (int i = 0; i < 3; i++)
								mag[i] >>= 1;
							peak >>= 1;
						end
						sq_sum = 0;
						for (int i = 0; i < 3; i++)
							sq_sum += mag[i] * mag[i];
						len = int_sqrt(sq_sum);
						for (int i = 0; i < 3; i++) begin
							q = (mag[i] * UNIT + len / 2) / len;
							if (q > UNIT)
								q = UNIT;
							nrm[i] = cr[i] < 0 ? -int'(q) : int'(q);
						end
					end
					// zero normals still count toward each corner
					for (int v = 0; v < 3; v++) begin
						for (int i = 0; i < 3; i++)
							normal_sum[corner[v]][i] = sat_sum(normal_sum[corner[v]][i], nrm[i]);
						if (tri_count[corner[v]] < 255)
							tri_count[corner[v]]++;
					end
					exp_res.result_kind = KIND_FACE;
				end
				CMD_READ: begin
					exp_res.result_kind = KIND_VERTEX;
					if (tri_count[it.corner_a] == 0) begin
						exp_res.degenerate = 1'b1;
					end else begin
						for (int i = 0; i < 3; i++)
							nrm[i] = rounded_avg(normal_sum[it.corner_a][i], tri_count[it.corner_a]);
					end
				end
				default: ;  // unused command: acknowledged, no state change
			endcase
			exp_res.normal_x = coord_t'(nrm[0]);
			exp_res.normal_y = coord_t'(nrm[1]);
			exp_res.normal_z = coord_t'(nrm[2]);
			expected_normals = {expected_normals, exp_res};
		endfunction

		// accepted result: compare with the oldest prediction
		function void check_result(normal_item_t got);
			normal_item_t want;
			if (expected_normals.size() == 0) begin
				$error("unexpected result transfer: result_kind %0d", got.result_kind);
				errors++;
				return;
			end
			want = expected_normals.pop_front();
			if (got.result_kind !== want.result_kind) begin
				$error("result_kind: expected %0d, got %0d", want.result_kind, got.result_kind);
				errors++;
			end
			if (got.normal_x !== want.normal_x) begin
				$error("normal_x: expected %0d, got %0d", want.normal_x, got.normal_x);
				errors++;
			end
			if (got.normal_y !== want.normal_y) begin
				$error("normal_y: expected %0d, got %0d", want.normal_y, got.normal_y);
				errors++;
			end
			if (got.normal_z !== want.normal_z) begin
				$error("normal_z: expected %0d, got %0d", want.normal_z, got.normal_z);
				errors++;
			end
			if (got.degenerate !== want.degenerate) begin
				$error("degenerate: expected %0d, got %0d", want.degenerate, got.degenerate);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   cycles = 0;
	int   tx_idle_pct;
	int   rx_idle_pct;
	logic rx_hold;
	logic pressure_go;

	normal_scoreboard sb;
	slot_t written_slots[$];
	logic  slot_written[SLOTS];

	mvne_cmd_if cmd();
	mvne_res_if res();

	mesh_vertex_normal_engine #(.VERTEX_SLOTS(SLOTS)) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd.sink),
		.res   (res.source)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run-length guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver: random ready, forced low during a long hold-off
	always @(negedge clk) begin
		if (!arst_n || rx_hold)
			res.ready = 1'b0;
		else
			res.ready = ($urandom_range(99) >= rx_idle_pct);
	end

	// long receiver hold-off while the sender keeps offering
	initial begin
		rx_hold = 1'b0;
		wait (pressure_go);
		@(negedge clk);
		rx_hold = 1'b1;
		repeat (800) @(negedge clk);
		rx_hold = 1'b0;
	end

	// transfer monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd.valid && cmd.ready)
				sb.note_command('{cmd.command, cmd.pos_x, cmd.pos_y, cmd.pos_z,
					cmd.corner_a, cmd.corner_b, cmd.corner_c});
			if (res.valid && res.ready)
				sb.check_result('{res.result_kind, res.normal_x, res.normal_y,
					res.normal_z, res.degenerate});
		end
	end

	task automatic send_item(cmd_item_t it);
		if ($urandom_range(99) < tx_idle_pct) begin
			cmd.valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		cmd.command = it.command;
		cmd.pos_x = it.pos_x;
		cmd.pos_y = it.pos_y;
		cmd.pos_z = it.pos_z;
		cmd.corner_a = it.corner_a;
		cmd.corner_b = it.corner_b;
		cmd.corner_c = it.corner_c;
		cmd.valid = 1'b1;
		do
			@(posedge clk);
		while (!cmd.ready);
		@(negedge clk);
		if (it.command == CMD_WRITE && !slot_written[it.corner_a]) begin
			slot_written[it.corner_a] = 1'b1;
			written_slots = {written_slots, it.corner_a};
		end
	endtask

	function automatic cmd_item_t make_item(code_t op, slot_t a, slot_t b, slot_t c,
			coord_t x, coord_t y, coord_t z);
		cmd_item_t it;
		it.command = op;
		it.corner_a = a;
		it.corner_b = b;
		it.corner_c = c;
		it.pos_x = x;
		it.pos_y = y;
		it.pos_z = z;
		return it;
	endfunction

	function automatic coord_t rand_coord();
		if ($urandom_range(9) < 7)
			return coord_t'($urandom_range(65535));
		return coord_t'($signed($urandom_range(1024)) - 512);
	endfunction

	function automatic slot_t pick_written();
		return written_slots[$urandom_range(written_slots.size() - 1)];
	endfunction

	// mixed random traffic; a large share repeats one fixed triangle to saturate
	function automatic cmd_item_t rand_item();
		int roll;
		slot_t s;
		roll = $urandom_range(99);
		if (roll < 40) begin
			case ($urandom_range(2))
				0: return make_item(CMD_ADD, HOT_ORIGIN, HOT_X, HOT_Y, 0, 0, 0);
				1: return make_item(CMD_ADD, HOT_X, HOT_Y, HOT_ORIGIN, 0, 0, 0);
				default: return make_item(CMD_ADD, HOT_Y, HOT_ORIGIN, HOT_X, 0, 0, 0);
			endcase
		end else if (roll < 55) begin
			s = slot_t'($urandom_range(3, SLOTS - 1));
			return make_item(CMD_WRITE, s, slot_t'($urandom), slot_t'($urandom),
				rand_coord(), rand_coord(), rand_coord());
		end else if (roll < 77) begin
			return make_item(CMD_ADD, pick_written(), pick_written(), pick_written(),
				rand_coord(), rand_coord(), rand_coord());
		end else if (roll < 96) begin
			s = ($urandom_range(3) == 0) ? slot_t'($urandom_range(2)) : slot_t'($urandom);
			return make_item(CMD_READ, s, slot_t'($urandom), slot_t'($urandom),
				rand_coord(), rand_coord(), rand_coord());
		end
		return make_item(code_t'(3), slot_t'($urandom), slot_t'($urandom), slot_t'($urandom),
			rand_coord(), rand_coord(), rand_coord());
	endfunction

	initial begin
		cmd_item_t directed[$];
		sb = new();
		tx_idle_pct = 20;
		rx_idle_pct = 66;
		pressure_go = 1'b0;
		foreach (slot_written[i])
			slot_written[i] = 1'b0;
		arst_n = 1'b0;
		cmd.valid = 1'b0;
		cmd.command = CMD_WRITE;
		cmd.pos_x = '0;
		cmd.pos_y = '0;
		cmd.pos_z = '0;
		cmd.corner_a = '0;
		cmd.corner_b = '0;
		cmd.corner_c = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, every command, degenerate and repeated corners
		directed = {directed, make_item(CMD_WRITE, HOT_ORIGIN, 0, 0, 0, 0, 0)};
		directed = {directed, make_item(CMD_WRITE, HOT_X, 0, 0, 16'sd32767, 0, 0)};
		directed = {directed, make_item(CMD_WRITE, HOT_Y, 0, 0, 0, 16'sd32767, 0)};
		directed = {directed, make_item(CMD_WRITE, 10'd1023, 10'd1023, 10'd1023,
			-16'sd32768, -16'sd32768, -16'sd32768)};
		directed = {directed, make_item(CMD_WRITE, 10'd512, 0, 0,
			16'sd32767, 16'sd32767, 16'sd32767)};
		directed = {directed, make_item(CMD_WRITE, 10'd3, 0, 0, -16'sd32768, 16'sd32767, 0)};
		directed = {directed, make_item(CMD_WRITE, 10'd4, 0, 0, 16'sd1, 16'sd1, 16'sd1)};
		directed = {directed, make_item(CMD_WRITE, 10'd5, 0, 0, 16'sd2, 16'sd2, 16'sd2)};
		directed = {directed, make_item(CMD_READ, HOT_ORIGIN, 0, 0, 0, 0, 0)};
		directed = {directed, make_item(CMD_ADD, HOT_ORIGIN, HOT_X, HOT_Y, 0, 0, 0)};
		directed = {directed, make_item(CMD_ADD, 10'd1023, 10'd512, 10'd3, 0, 0, 0)};
		directed = {directed, make_item(CMD_ADD, 10'd3, 10'd1023, 10'd512, 0, 0, 0)};
		directed = {directed, make_item(CMD_ADD, HOT_ORIGIN, 10'd4, 10'd5, 0, 0, 0)};
		directed = {directed, make_item(CMD_ADD, 10'd4, 10'd4, 10'd1023, 0, 0, 0)};
		directed = {directed, make_item(CMD_ADD, 10'd512, 10'd3, 10'd3, 0, 0, 0)};
		directed = {directed, make_item(CMD_READ, HOT_ORIGIN, 0, 0, 0, 0, 0)};
		directed = {directed, make_item(CMD_READ, 10'd4, 0, 0, 0, 0, 0)};
		directed = {directed, make_item(CMD_READ, 10'd1023, 0, 0, 0, 0, 0)};
		directed = {directed, make_item(CMD_READ, 10'd700, 0, 0, 0, 0, 0)};
		directed = {directed, make_item(code_t'(3), 10'd1023, 10'd1023, 10'd1023,
			-16'sd1, -16'sd1, -16'sd1)};
		directed = {directed, make_item(CMD_READ, 10'd3, 0, 0, 0, 0, 0)};
		foreach (directed[i])
			send_item(directed[i]);

		// random traffic in three idling phases
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 3) begin
				tx_idle_pct = 66;
				rx_idle_pct = 20;
			end else if (n == 2 * RANDOM_ITEMS / 3) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
				pressure_go = 1'b1;
			end
			send_item(rand_item());
		end
		cmd.valid = 1'b0;

		// drain, then let the block settle
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
